FILE: hdl/skl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// skl_pkg: shared types and constants for the sorted key list
// Key width, default depth, request opcodes, result codes, sequencer states
// and the compare unit's result bundle.
// ----------------------------------------------------------------------------
package skl_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int KEY_W     = 32;
  localparam int OP_W      = 2;
  localparam int POS_W     = 6;
  localparam int CNT_OUT_W = 7;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;
  localparam logic [OP_W-1:0] OP_NOP    = 2'd3;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_RANGE     = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CHK,
    ST_DEL_RD,
    ST_DEL_CHK,
    ST_SHF_RD,
    ST_SHF_WR,
    ST_RD_WAIT,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic less;
    logic equal;
  } cmp_res_t;

endpackage
`default_nettype wire

FILE: hdl/skl_cmp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// skl_cmp: shared key compare unit
// Signed less-than and equality of a stored key against the request key.
// ----------------------------------------------------------------------------
module skl_cmp (
  input  wire logic signed [skl_pkg::KEY_W-1:0] stored_key,
  input  wire logic signed [skl_pkg::KEY_W-1:0] req_key,
  output skl_pkg::cmp_res_t                     res
);
  import skl_pkg::*;

  always_comb begin
    res.less  = (stored_key < req_key);
    res.equal = (stored_key == req_key);
  end

endmodule
`default_nettype wire

FILE: hdl/skl_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// skl_mem: key storage
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module skl_mem #(
  parameter int DEPTH = skl_pkg::DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic                            clk,
  input  wire logic                            we,
  input  wire logic [AW-1:0]                   waddr,
  input  wire logic signed [skl_pkg::KEY_W-1:0] wdata,
  input  wire logic [AW-1:0]                   raddr,
  output logic signed [skl_pkg::KEY_W-1:0]      rdata
);
  import skl_pkg::*;

  logic signed [KEY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: hdl/sorted_key_list.sv
`timescale 1ns / 1ps
`default_nettype none
// Sequencing from the accepted request to ST_RESP: a read passes through ST_RD_WAIT; a full
//   insert, an out-of-range read and a no-op go straight there; an insert walks ST_INS_RD
//   and ST_INS_CHK down from the top past every key at or above the new key; a delete
//   searches with ST_DEL_RD and ST_DEL_CHK, then on a hit shifts with ST_SHF_RD/ST_SHF_WR.
// Requests: one at a time; the next is taken the cycle after the result is queued, and the
//   result waits in ST_RESP while the output slot is stalled.
// Reset: synchronous active-low rst_n empties the list and drops any pending result.
// sorted_key_list: ordered store of signed keys
// Insert, delete and indexed read on an ascending list, run by a small
// sequencer around one key memory and one shared compare unit.
// ----------------------------------------------------------------------------
module sorted_key_list #(
  parameter int DEPTH = skl_pkg::DEPTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [skl_pkg::OP_W-1:0]            in_opcode,
  input  wire logic signed [skl_pkg::KEY_W-1:0]    in_key,
  input  wire logic [skl_pkg::POS_W-1:0]           in_position,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [1:0]                               out_status,
  output logic signed [skl_pkg::KEY_W-1:0]         out_key_out,
  output logic [skl_pkg::CNT_OUT_W-1:0]            out_count
);
  import skl_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  // Sequencer state and working registers
  state_t                  state_r, state_nxt;
  logic [CW-1:0]           cnt_r, cnt_nxt;
  logic [CW-1:0]           idx_r, idx_nxt;
  logic signed [KEY_W-1:0] key_r, key_nxt;
  status_t                 res_status_r, res_status_nxt;
  logic signed [KEY_W-1:0] res_key_r, res_key_nxt;

  // Output register
  logic                    out_valid_r, out_valid_nxt;
  status_t                 out_status_r, out_status_nxt;
  logic signed [KEY_W-1:0] out_key_r, out_key_nxt;
  logic [CNT_OUT_W-1:0]    out_count_r, out_count_nxt;

  // Memory and compare unit hookup
  logic                    mem_we;
  logic [AW-1:0]           mem_waddr;
  logic signed [KEY_W-1:0] mem_wdata;
  logic [AW-1:0]           mem_raddr;
  logic signed [KEY_W-1:0] mem_rdata;
  cmp_res_t                cmp;

  logic                    in_acc;
  logic                    out_free;
  logic                    list_full;
  logic                    pos_ok;
  logic [CW-1:0]           idx_dec;
  logic [CW-1:0]           idx_inc;

  skl_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // One compare unit serves both the insert walk and the delete search.
  skl_cmp u_cmp (
    .stored_key (mem_rdata),
    .req_key    (key_r),
    .res        (cmp)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  // The output slot can take a result when empty or being drained this cycle.
  assign out_free  = !out_valid_r || !out_stall;
  assign list_full = (cnt_r == CW'(DEPTH));
  assign pos_ok    = (32'(in_position) < 32'(cnt_r));
  assign idx_dec   = idx_r - CW'(1);
  assign idx_inc   = idx_r + CW'(1);

  // Next-state logic
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_opcode)
            OP_INSERT: state_nxt = list_full ? ST_RESP : ST_INS_RD;
            OP_DELETE: state_nxt = ST_DEL_RD;
            OP_READ:   state_nxt = pos_ok ? ST_RD_WAIT : ST_RESP;
            OP_NOP:    state_nxt = ST_RESP;
          endcase
        end
      end
      ST_INS_RD:  state_nxt = (idx_r == '0) ? ST_RESP : ST_INS_CHK;
      ST_INS_CHK: state_nxt = cmp.less ? ST_RESP : ST_INS_RD;
      ST_DEL_RD:  state_nxt = (idx_r == cnt_r) ? ST_RESP : ST_DEL_CHK;
      ST_DEL_CHK: state_nxt = cmp.equal ? ST_SHF_RD : ST_DEL_RD;
      ST_SHF_RD:  state_nxt = (idx_inc == cnt_r) ? ST_RESP : ST_SHF_WR;
      ST_SHF_WR:  state_nxt = ST_SHF_RD;
      ST_RD_WAIT: state_nxt = ST_RESP;
      ST_RESP:    state_nxt = out_free ? ST_IDLE : ST_RESP;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    cnt_nxt        = cnt_r;
    idx_nxt        = idx_r;
    key_nxt        = key_r;
    res_status_nxt = res_status_r;
    res_key_nxt    = res_key_r;
    mem_we         = 1'b0;
    mem_waddr      = idx_r[AW-1:0];
    mem_wdata      = key_r;
    mem_raddr      = idx_r[AW-1:0];

    unique case (state_r)
      ST_IDLE: begin
        // Issue the indexed read right away so data lands in ST_RD_WAIT.
        mem_raddr = AW'(in_position);
        if (in_acc) begin
          key_nxt        = in_key;
          res_status_nxt = STAT_OK;
          res_key_nxt    = '0;
          unique case (in_opcode)
            OP_INSERT: begin
              // Walk down from the top, shifting keys up until one is less.
              idx_nxt = cnt_r;
              if (list_full) begin
                res_status_nxt = STAT_FULL;
              end
            end
            OP_DELETE: begin
              idx_nxt = '0;
            end
            OP_READ: begin
              if (!pos_ok) begin
                res_status_nxt = STAT_RANGE;
              end
            end
            OP_NOP: begin
              res_status_nxt = STAT_OK;
            end
          endcase
        end
      end
      ST_INS_RD: begin
        mem_raddr = idx_dec[AW-1:0];
        if (idx_r == '0) begin
          // Reached the bottom: the new key is the smallest.
          mem_we    = 1'b1;
          mem_waddr = '0;
          cnt_nxt   = cnt_r + CW'(1);
        end
      end
      ST_INS_CHK: begin
        mem_we = 1'b1;
        if (cmp.less) begin
          // Slot found just above a smaller key: drop the new key in.
          mem_wdata = key_r;
          cnt_nxt   = cnt_r + CW'(1);
        end else begin
          // Move this key up one slot and keep walking down.
          mem_wdata = mem_rdata;
          idx_nxt   = idx_dec;
        end
      end
      ST_DEL_RD: begin
        if (idx_r == cnt_r) begin
          res_status_nxt = STAT_NOT_FOUND;
        end
      end
      ST_DEL_CHK: begin
        if (!cmp.equal) begin
          idx_nxt = idx_inc;
        end
      end
      ST_SHF_RD: begin
        mem_raddr = idx_inc[AW-1:0];
        if (idx_inc == cnt_r) begin
          cnt_nxt = cnt_r - CW'(1);
        end
      end
      ST_SHF_WR: begin
        // Pull the next key down over the removed one.
        mem_we    = 1'b1;
        mem_wdata = mem_rdata;
        idx_nxt   = idx_inc;
      end
      ST_RD_WAIT: begin
        res_key_nxt = mem_rdata;
      end
      ST_RESP: begin
      end
      default: begin
      end
    endcase
  end

  // Output register: load the finished result, clear when taken.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_key_nxt    = out_key_r;
    out_count_nxt  = out_count_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if ((state_r == ST_RESP) && out_free) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = res_status_r;
      out_key_nxt    = res_key_r;
      out_count_nxt  = CNT_OUT_W'(cnt_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    key_r        <= key_nxt;
    res_status_r <= res_status_nxt;
    res_key_r    <= res_key_nxt;
    out_status_r <= out_status_nxt;
    out_key_r    <= out_key_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_key_out = out_key_r;
  assign out_count   = out_count_r;

  // The list never holds more keys than the memory has entries.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("key count exceeds depth");

  // The count moves only on the step that completes a request.
  a_cnt_at_resp: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$stable(cnt_r)) |-> (state_r == ST_RESP))
    else $error("count changed outside request completion");

  // Memory writes happen only in the insert walk and the delete shift.
  a_we_states: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == ST_INS_RD || state_r == ST_INS_CHK || state_r == ST_SHF_WR))
    else $error("memory written outside a shifting state");

endmodule
`default_nettype wire

FILE: test/skl_order_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skl_order_checker: reply predictor and comparator for the sorted key list
// Mirrors the ordered key list from every accepted request, queues the
// predicted reply and compares each accepted reply with the oldest one.
// ----------------------------------------------------------------------------
module skl_order_checker #(
  parameter int DEPTH = skl_pkg::DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic                               in_stall,
  input  logic [skl_pkg::OP_W-1:0]           in_opcode,
  input  logic signed [skl_pkg::KEY_W-1:0]   in_key,
  input  logic [skl_pkg::POS_W-1:0]          in_position,
  input  logic                               out_valid,
  input  logic                               out_stall,
  input  logic [1:0]                         out_status,
  input  logic signed [skl_pkg::KEY_W-1:0]   out_key_out,
  input  logic [skl_pkg::CNT_OUT_W-1:0]      out_count,
  output int                                 mismatches,
  output int                                 outstanding,
  output int                                 held_count
);
  import skl_pkg::*;

  typedef struct packed {
    status_t                 status;
    logic signed [KEY_W-1:0] key;
    logic [CNT_OUT_W-1:0]    count;
  } reply_t;

  logic signed [KEY_W-1:0] shadow_keys[$];
  reply_t                  reply_q[$];
  int                      fail_cnt = 0;

  // Apply one request to the mirrored list and return the reply it yields.
  function automatic reply_t apply_request(logic [OP_W-1:0] op,
                                           logic signed [KEY_W-1:0] key,
                                           logic [POS_W-1:0] pos);
    reply_t r;
    int     slot;
    r.status = STAT_OK;
    r.key    = '0;
    slot     = 0;
    case (op)
      OP_INSERT: begin
        if (shadow_keys.size() >= DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          while (slot < shadow_keys.size() && shadow_keys[slot] < key) slot++;
          shadow_keys.insert(slot, key);
        end
      end
      OP_DELETE: begin
        while (slot < shadow_keys.size() && shadow_keys[slot] != key) slot++;
        if (slot >= shadow_keys.size()) begin
          r.status = STAT_NOT_FOUND;
        end else begin
          shadow_keys.delete(slot);
        end
      end
      OP_READ: begin
        if (int'(pos) < shadow_keys.size()) begin
          r.key = shadow_keys[pos];
        end else begin
          r.status = STAT_RANGE;
        end
      end
      default: begin
      end
    endcase
    r.count = CNT_OUT_W'(shadow_keys.size());
    return r;
  endfunction

  always @(posedge clk) begin : watch
    reply_t exp_r;
    if (!rst_n) begin
      shadow_keys.delete();
      reply_q.delete();
    end else begin
      // Retire the reply first: it always belongs to an earlier request.
      if (out_valid && !out_stall) begin
        if (reply_q.size() == 0) begin
          if (fail_cnt < 10) begin
            $display("%0t: reply with no request pending: status %0d key %0d count %0d",
                     $realtime, out_status, out_key_out, out_count);
          end
          fail_cnt++;
        end else begin
          exp_r = reply_q.pop_front();
          if (out_status !== exp_r.status || out_key_out !== exp_r.key ||
              out_count !== exp_r.count) begin
            if (fail_cnt < 10) begin
              $write("%0t: reply differs: status exp %0d got %0d, ",
                     $realtime, exp_r.status, out_status);
              $display("key exp %0d got %0d, count exp %0d got %0d",
                       exp_r.key, out_key_out, exp_r.count, out_count);
            end
            fail_cnt++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        reply_q.push_back(apply_request(in_opcode, in_key, in_position));
      end
    end
    mismatches  <= fail_cnt;
    outstanding <= reply_q.size();
    held_count  <= shadow_keys.size();
  end

endmodule

FILE: test/tb_sorted_key_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_key_list: self-checking bench for the sorted key list
// Drives directed corner requests, then random phases of mixed traffic,
// fill-to-full runs, drain-down runs and read sweeps, with random gaps on
// both channels; a side checker predicts and compares every reply.
// ----------------------------------------------------------------------------
module tb_sorted_key_list;
  import skl_pkg::*;

  localparam int DEPTH        = DEPTH_DEF;
  localparam int RANDOM_ITEMS = 1750;
  localparam int CYCLE_LIMIT  = 1_200_000;
  localparam int DRAIN_CYCLES = 300;

  localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
  localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic [OP_W-1:0]         in_opcode;
  logic signed [KEY_W-1:0] in_key;
  logic [POS_W-1:0]        in_position;
  logic                    out_valid;
  logic                    out_stall;
  logic [1:0]              out_status;
  logic signed [KEY_W-1:0] out_key_out;
  logic [CNT_OUT_W-1:0]    out_count;

  int mismatches;
  int outstanding;
  int held_count;
  int cycle_count = 0;
  int sent        = 0;
  bit quiet;                          // no gaps on either channel while set

  // Keys recently inserted; delete requests mostly pick from here.
  logic signed [KEY_W-1:0] key_pool[$];

  always #2 clk = ~clk;

  sorted_key_list #(
    .DEPTH(DEPTH)
  ) i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_opcode   (in_opcode),
    .in_key      (in_key),
    .in_position (in_position),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_status  (out_status),
    .out_key_out (out_key_out),
    .out_count   (out_count)
  );

  skl_order_checker #(
    .DEPTH(DEPTH)
  ) i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_opcode   (in_opcode),
    .in_key      (in_key),
    .in_position (in_position),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_status  (out_status),
    .out_key_out (out_key_out),
    .out_count   (out_count),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .held_count  (held_count)
  );

  // Stall the reply channel in about a third of the cycles, never while quiet.
  always @(posedge clk) begin
    out_stall <= rst_n && !quiet && ($urandom_range(99) < 35);
  end

  // Watchdog: end the run as a mismatch once the cycle limit is reached.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Keys: extremes now and then, a narrow band for duplicates, else anything.
  function automatic logic signed [KEY_W-1:0] rand_key();
    int sel;
    sel = $urandom_range(15);
    if (sel == 0) return KEY_MIN;
    if (sel == 1) return KEY_MAX;
    if (sel < 7) return int'($urandom_range(40)) - 20;
    return $urandom;
  endfunction

  // Pick a key to delete: mostly one taken from the pool, else a random one.
  function automatic logic signed [KEY_W-1:0] pick_victim();
    int                      idx;
    logic signed [KEY_W-1:0] k;
    if (key_pool.size() == 0 || $urandom_range(9) < 2) return rand_key();
    idx = $urandom_range(key_pool.size() - 1);
    k   = key_pool[idx];
    key_pool.delete(idx);
    return k;
  endfunction

  // Mostly an index inside the list, sometimes any index at all.
  function automatic logic [POS_W-1:0] pick_index();
    if (held_count > 0 && $urandom_range(9) < 7) begin
      return POS_W'($urandom_range(held_count - 1));
    end
    return POS_W'($urandom_range(63));
  endfunction

  // Present one request and hold it until the block takes it, then maybe idle.
  task automatic send_request(input logic [OP_W-1:0] op,
                              input logic signed [KEY_W-1:0] key,
                              input logic [POS_W-1:0] pos);
    in_valid    <= 1'b1;
    in_opcode   <= op;
    in_key      <= key;
    in_position <= pos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
    if (op == OP_INSERT) begin
      key_pool.push_back(key);
      if (key_pool.size() > 96) key_pool.delete(0);
    end
    if (!quiet && $urandom_range(99) < 35) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // Drop valid and hold off until every predicted reply has come back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // One random request: insert, delete, read or an idle opcode.
  task automatic mixed_request();
    int roll;
    int ins_pct;
    roll    = $urandom_range(99);
    ins_pct = (held_count < DEPTH / 2) ? 45 : 30;
    if (roll < ins_pct) begin
      send_request(OP_INSERT, rand_key(), POS_W'($urandom_range(63)));
    end else if (roll < ins_pct + 30) begin
      send_request(OP_DELETE, pick_victim(), POS_W'($urandom_range(63)));
    end else if (roll < 95) begin
      send_request(OP_READ, $urandom, pick_index());
    end else begin
      send_request(OP_NOP, $urandom, POS_W'($urandom_range(63)));
    end
  endtask

  initial begin : stimulus
    int goal;
    int start;
    int n;
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_opcode   <= OP_NOP;
    in_key      <= '0;
    in_position <= '0;
    quiet       <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty-list corners, extremes, duplicates, absent keys.
    send_request(OP_READ, '0, '0);
    send_request(OP_DELETE, 5, '0);
    send_request(OP_NOP, -1, '1);
    send_request(OP_INSERT, 0, '0);
    send_request(OP_INSERT, KEY_MAX, '0);
    send_request(OP_INSERT, KEY_MIN, '0);
    send_request(OP_INSERT, -1, '0);
    send_request(OP_INSERT, 0, '0);
    send_request(OP_INSERT, 1, '0);
    for (int i = 0; i <= 6; i++) send_request(OP_READ, '0, POS_W'(i));
    send_request(OP_READ, '1, '1);
    send_request(OP_DELETE, 0, '0);
    send_request(OP_DELETE, 7, '0);
    send_request(OP_DELETE, KEY_MIN, '0);
    send_request(OP_DELETE, KEY_MAX, '0);
    send_request(OP_READ, '0, '0);
    send_request(OP_NOP, KEY_MAX, '0);
    send_request(OP_DELETE, -1, '0);

    // Random phases until enough requests have gone in.
    start = sent;
    goal  = sent + RANDOM_ITEMS;
    while (sent < goal) begin
      // Hold a long stretch with no gaps on either side.
      quiet <= (sent >= start + 700 && sent < start + 1000);
      case ($urandom_range(9))
        6, 7: begin
          // Fill to full and push a few more inserts against the limit.
          drain();
          n = DEPTH + 4 - held_count;
          repeat (n) send_request(OP_INSERT, rand_key(), POS_W'($urandom_range(63)));
          send_request(OP_READ, '0, '1);
          send_request(OP_READ, '0, '0);
          send_request(OP_READ, '0, pick_index());
        end
        8: begin
          // Drain the list down, mostly deletes of known keys.
          drain();
          n = held_count + 3;
          repeat (n) begin
            if ($urandom_range(3) != 0) begin
              send_request(OP_DELETE, pick_victim(), POS_W'($urandom_range(63)));
            end else begin
              send_request(OP_READ, $urandom, pick_index());
            end
          end
        end
        9: begin
          // Sweep reads across the whole index range.
          repeat (20) send_request(OP_READ, $urandom, POS_W'($urandom_range(63)));
        end
        default: begin
          repeat ($urandom_range(10, 40)) mixed_request();
        end
      endcase
    end
    quiet <= 1'b0;

    // Wait out the last replies, then give stray ones time to show up.
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/skl_pkg.sv
hdl/skl_cmp.sv
hdl/skl_mem.sv
hdl/sorted_key_list.sv
test/skl_order_checker.sv
test/tb_sorted_key_list.sv
